FILE: design/pf_pkg.sv
// shared constants, types and letter/cell helper functions for the playfair decryptor
package pf_pkg;

    localparam int GRID_SIZE    = 5;
    localparam int CELL_COUNT   = GRID_SIZE * GRID_SIZE;
    localparam int LETTER_COUNT = 26;
    localparam int LETTER_W     = 5;
    localparam int CELL_W       = $clog2(CELL_COUNT);
    localparam int ROW_W        = $clog2(GRID_SIZE);

    localparam logic [LETTER_W-1:0] CODE_A = LETTER_W'(0);
    localparam logic [LETTER_W-1:0] CODE_I = LETTER_W'(8);
    localparam logic [LETTER_W-1:0] CODE_J = LETTER_W'(9);
    localparam logic [LETTER_W-1:0] CODE_Z = LETTER_W'(25);

    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELL_COUNT);

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_KEY     = 2'd1,
        REQ_FINISH  = 2'd2,
        REQ_DECRYPT = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_CELL,
        ST_GRID
    } state_t;

    typedef enum logic {
        STATUS_OK        = 1'b0,
        STATUS_NOT_READY = 1'b1
    } status_t;

    // cipher letter: codes above z read as z, j reads as i
    function automatic logic [LETTER_W-1:0] fold_cipher(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] r;
        r = (v > CODE_Z) ? CODE_Z : v;
        if (r == CODE_J)
        begin
            r = CODE_I;
        end
        return r;
    endfunction

    // row of a cell by compare chain against multiples of the grid size
    function automatic logic [ROW_W-1:0] cell_row(input logic [CELL_W-1:0] c);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int k = 1; k < GRID_SIZE; k++)
        begin
            if (c >= CELL_W'(k * GRID_SIZE))
            begin
                r = ROW_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [ROW_W-1:0] col);
        logic [CELL_W-1:0] base;
        base = CELL_W'(row) * CELL_W'(GRID_SIZE);
        return base + CELL_W'(col);
    endfunction

endpackage

FILE: design/pf_ram2r.sv
// generic synchronous ram, one write port and two registered read ports
module pf_ram2r #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 5,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: design/pf_locate.sv
// digraph rule: maps two cipher cells to the two plaintext cells
module pf_locate (
    input  logic [pf_pkg::CELL_W-1:0] cell_a,
    input  logic [pf_pkg::CELL_W-1:0] cell_b,
    output logic [pf_pkg::CELL_W-1:0] plain_cell_a,
    output logic [pf_pkg::CELL_W-1:0] plain_cell_b
);
    import pf_pkg::*;

    localparam logic [ROW_W-1:0] LAST_IDX = ROW_W'(GRID_SIZE - 1);

    logic [ROW_W-1:0] row_a, row_b, col_a, col_b;
    logic [ROW_W-1:0] out_row_a, out_row_b, out_col_a, out_col_b;
    logic [CELL_W-1:0] base_a, base_b;

    always_comb
    begin
        row_a  = cell_row(cell_a);
        row_b  = cell_row(cell_b);
        base_a = cell_addr(row_a, '0);
        base_b = cell_addr(row_b, '0);
        col_a  = ROW_W'(cell_a - base_a);
        col_b  = ROW_W'(cell_b - base_b);

        out_row_a = row_a;
        out_row_b = row_b;
        out_col_a = col_a;
        out_col_b = col_b;
        priority if (row_a == row_b)
        begin
            // same row: shift left with wrap
            out_col_a = (col_a == '0) ? LAST_IDX : col_a - ROW_W'(1);
            out_col_b = (col_b == '0) ? LAST_IDX : col_b - ROW_W'(1);
        end
        else if (col_a == col_b)
        begin
            // same column: shift up with wrap
            out_row_a = (row_a == '0) ? LAST_IDX : row_a - ROW_W'(1);
            out_row_b = (row_b == '0) ? LAST_IDX : row_b - ROW_W'(1);
        end
        else
        begin
            // rectangle: swap columns
            out_col_a = col_b;
            out_col_b = col_a;
        end

        plain_cell_a = cell_addr(out_row_a, out_col_a);
        plain_cell_b = cell_addr(out_row_b, out_col_b);
    end

endmodule

FILE: design/playfair_digraph_decryptor.sv
// top level: playfair key square builder and digraph decryptor
//
// A transfer is taken when start is high and busy is low. Start, key letter,
// an early decrypt (status 1, letters zero) and a finish on a ready square
// complete without leaving idle, so busy stays low; a finish request on an
// unfinished square walks the alphabet one letter a cycle through the key
// square memory, with busy high from a to z. A decrypt on a finished square
// goes through one registered read of the letter-to-cell memory, one
// registered read of the key square memory, then the output register. Each
// result is shown for exactly one cycle with done high and is not held, so it
// must be captured in that cycle.
module playfair_digraph_decryptor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  req_type,
    input  logic [pf_pkg::LETTER_W-1:0] letter_a,
    input  logic [pf_pkg::LETTER_W-1:0] letter_b,
    output logic                        done,
    output logic [pf_pkg::LETTER_W-1:0] plain_a,
    output logic [pf_pkg::LETTER_W-1:0] plain_b,
    output logic                        status
);
    import pf_pkg::*;

    state_t state_reg, state_next;
    logic [LETTER_COUNT-1:0] used_reg, used_next;
    logic [CELL_W-1:0] fill_reg, fill_next;
    logic ready_reg, ready_next;
    logic [LETTER_W-1:0] walk_reg, walk_next;
    logic done_reg, done_next;
    logic [LETTER_W-1:0] plain_a_reg, plain_a_next;
    logic [LETTER_W-1:0] plain_b_reg, plain_b_next;
    logic status_reg, status_next;

    req_t req;
    logic accept;
    logic place_req;
    logic [LETTER_W-1:0] place_letter;
    logic place_we;

    logic [LETTER_W-1:0] map_raddr_a, map_raddr_b;
    logic [CELL_W-1:0] map_rdata_a, map_rdata_b;
    logic [CELL_W-1:0] grid_raddr_a, grid_raddr_b;
    logic [LETTER_W-1:0] grid_rdata_a, grid_rdata_b;

    assign req    = req_t'(req_type);
    assign accept = start && (state_reg == ST_IDLE);

    // letter to place: alphabet walk during fill, otherwise the key letter
    always_comb
    begin
        place_req    = 1'b0;
        place_letter = (letter_a == CODE_J) ? CODE_I : letter_a;
        if (state_reg == ST_FILL)
        begin
            place_letter = walk_reg;
            place_req    = (walk_reg != CODE_J);
        end
        else if (accept && req == REQ_KEY)
        begin
            place_req = (letter_a <= CODE_Z);
        end
        place_we = place_req && !used_reg[place_letter] && (fill_reg < LAST_CELL);
    end

    assign map_raddr_a = fold_cipher(letter_a);
    assign map_raddr_b = fold_cipher(letter_b);

    pf_ram2r #(
        .DEPTH (LETTER_COUNT),
        .WIDTH (CELL_W)
    ) u_letter_cell (
        .clk     (clk),
        .we      (place_we),
        .waddr   (place_letter),
        .wdata   (fill_reg),
        .raddr_a (map_raddr_a),
        .raddr_b (map_raddr_b),
        .rdata_a (map_rdata_a),
        .rdata_b (map_rdata_b)
    );

    pf_locate u_locate (
        .cell_a       (map_rdata_a),
        .cell_b       (map_rdata_b),
        .plain_cell_a (grid_raddr_a),
        .plain_cell_b (grid_raddr_b)
    );

    pf_ram2r #(
        .DEPTH (CELL_COUNT),
        .WIDTH (LETTER_W)
    ) u_key_grid (
        .clk     (clk),
        .we      (place_we),
        .waddr   (fill_reg),
        .wdata   (place_letter),
        .raddr_a (grid_raddr_a),
        .raddr_b (grid_raddr_b),
        .rdata_a (grid_rdata_a),
        .rdata_b (grid_rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            used_reg   <= '0;
            fill_reg   <= '0;
            ready_reg  <= 1'b0;
            walk_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            fill_reg   <= fill_next;
            ready_reg  <= ready_next;
            walk_reg   <= walk_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plain_a_reg <= plain_a_next;
        plain_b_reg <= plain_b_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        fill_next    = fill_reg;
        ready_next   = ready_reg;
        walk_next    = walk_reg;
        done_next    = 1'b0;
        plain_a_next = plain_a_reg;
        plain_b_next = plain_b_reg;
        status_next  = status_reg;

        if (place_we)
        begin
            used_next[place_letter] = 1'b1;
            fill_next = fill_reg + CELL_W'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req)
                        REQ_START:
                        begin
                            used_next  = '0;
                            fill_next  = '0;
                            ready_next = 1'b0;
                        end
                        REQ_KEY:
                        begin
                        end
                        REQ_FINISH:
                        begin
                            if (!ready_reg)
                            begin
                                walk_next  = CODE_A;
                                state_next = ST_FILL;
                            end
                        end
                        REQ_DECRYPT:
                        begin
                            if (ready_reg)
                            begin
                                state_next = ST_CELL;
                            end
                            else
                            begin
                                plain_a_next = '0;
                                plain_b_next = '0;
                                status_next  = STATUS_NOT_READY;
                                done_next    = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                walk_next = walk_reg + LETTER_W'(1);
                if (walk_reg == CODE_Z)
                begin
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CELL:
            begin
                state_next = ST_GRID;
            end
            ST_GRID:
            begin
                plain_a_next = grid_rdata_a;
                plain_b_next = grid_rdata_b;
                status_next  = STATUS_OK;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign plain_a = plain_a_reg;
    assign plain_b = plain_b_reg;
    assign status  = status_reg;

endmodule
